// ===== hdl/gain_saturate_level_meter_ring_macros.svh =====
// Assertion macros shared by the level meter ring RTL.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef GAIN_SATURATE_LEVEL_METER_RING_MACROS_SVH
`define GAIN_SATURATE_LEVEL_METER_RING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GSL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gsl_pkg.sv =====
// Package of the gain, saturate and level meter ring block.
// Holds sizes, codes, register and item types; depends on nothing.
package gsl_pkg;
	localparam int RING_DEPTH = 65536;
	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int MAX_POINTS = 64;
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W = 16;
	localparam int VOL_W = 13;
	localparam int BOOST_W = 14;
	localparam int CH_W = 4;
	localparam int PTS_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;
	localparam int GAIN_W = 14;
	localparam int Q_SHIFT = 12;
	localparam int PROD1_W = VOL_W + BOOST_W;
	localparam int PROD2_W = SAMPLE_W + GAIN_W + 1;
	localparam int QT_W = PROD2_W - Q_SHIFT;
	localparam int MAX_CH = 8;
	localparam int MAG_W = SAMPLE_W + 1;
	localparam int SUM_W = MAG_W + $clog2(MAX_CH);
	localparam int DIV_W = (ADDR_W + 1 > SUM_W + 1) ? ADDR_W + 1 : SUM_W + 1;
	localparam int DVS_W = $clog2(MAX_POINTS * MAX_CH + 1);
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int UNITY_LO = 4092;
	localparam int UNITY_HI = 4100;
	localparam int VOL_MAX = 4096;
	localparam int LEVEL_MAX = 32768;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_LEVEL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOLUME = 3'd0,
		CFG_BOOST_EN = 3'd1,
		CFG_BOOST_GAIN = 3'd2,
		CFG_CHANNELS = 3'd3,
		CFG_POINTS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume;
		logic boost_enable;
		logic [BOOST_W-1:0] boost_gain;
		logic [CH_W-1:0] channel_count;
		logic [PTS_W-1:0] point_count;
	} cfg_t;

	typedef struct packed {
		logic is_read;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT,
		ST_SDIV,
		ST_RD,
		ST_DRAIN,
		ST_LGO,
		ST_LDIV,
		ST_LEMIT
	} back_st_t;
endpackage

// ===== hdl/gsl_if.sv =====
// Handshake interfaces for the request and result channels.
// Depends on gsl_pkg for field widths.
interface gsl_req_if import gsl_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	logic signed [SAMPLE_W-1:0] sample_in;
	modport source(output valid, cmd, sample_in, input ready);
	modport sink(input valid, cmd, sample_in, output ready);
endinterface

interface gsl_rsp_if import gsl_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [LEVEL_W-1:0] level;
	logic last;
	modport source(output valid, kind, sample_out, level, last, input ready);
	modport sink(input valid, kind, sample_out, level, last, output ready);
endinterface

// ===== hdl/gsl_front.sv =====
// Front end: accepts request words, classifies them and queues them.
// Depends on gsl_pkg and gsl_if.
module gsl_front import gsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gsl_req_if.sink req,
	output item_t q_item,
	output logic q_valid,
	input  logic q_pop
);
	item_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	item_t entry;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign entry.is_read = (req.cmd == CMD_READ);
	assign entry.sample = req.sample_in;
	assign q_item = fifo_q[rd_ptr_q];
	assign q_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== hdl/gsl_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gsl_pkg for operand widths.
module gsl_div import gsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic busy,
	output logic done,
	output logic [DIV_W-1:0] quotient
);
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits = (trial >= {1'b0, dvs_q});
	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hdl/gsl_back.sv =====
// Back end: scales samples, keeps the level ring and walks it for level reads.
// Depends on gsl_pkg, gsl_if, gsl_div and the assertion macro header.
module gsl_back import gsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  item_t q_item,
	input  logic q_valid,
	output logic q_pop,
	gsl_rsp_if.source rsp
);
	back_st_t state_q, state_d;

	logic [VOL_W-1:0] vol_c;
	logic [CH_W-1:0] ch_c;
	logic [PTS_W-1:0] pts_c;

	logic signed [SAMPLE_W-1:0] samp_q;
	logic [PROD1_W-1:0] prod1_q;
	logic [GAIN_W-1:0] gain;
	logic unity_q;
	logic signed [PROD2_W-1:0] prod2_q;
	logic signed [QT_W-1:0] q_trunc;
	logic [SAMPLE_W-1:0] sat_res;

	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [ADDR_W-1:0] write_pos_q;
	logic wrapped_q;
	logic ring_we;
	logic [ADDR_W-1:0] rd_addr;
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic rd_ok_s1;
	logic rd_vld_s1;
	logic rd_issue;
	logic [MAG_W-1:0] mag;

	logic [ADDR_W-1:0] step_q;
	logic [ADDR_W-1:0] base_q;
	logic [CH_W-1:0] chan_q;
	logic [PTS_W-1:0] pt_q;
	logic [SUM_W-1:0] sum_q;
	logic [DIV_W-1:0] stride;
	logic [DIV_W+CH_W-1:0] step_full;
	logic [LEVEL_W-1:0] lvl;
	logic pt_last;

	logic div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic div_busy;
	logic div_done;
	logic [DIV_W-1:0] div_quo;

	logic out_free;
	logic out_load;
	logic out_kind_d;
	logic signed [SAMPLE_W-1:0] out_samp_d;
	logic [LEVEL_W-1:0] out_lvl_d;
	logic out_last_d;
	logic out_valid_q;
	logic out_kind_q;
	logic signed [SAMPLE_W-1:0] out_samp_q;
	logic [LEVEL_W-1:0] out_lvl_q;
	logic out_last_q;

	// Register values outside their range are pulled back into it.
	assign vol_c = (cfg.volume > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : cfg.volume;
	assign ch_c = (cfg.channel_count == '0) ? CH_W'(1) :
		(cfg.channel_count > CH_W'(MAX_CH)) ? CH_W'(MAX_CH) : cfg.channel_count;
	assign pts_c = (cfg.point_count == '0) ? PTS_W'(1) :
		(cfg.point_count > PTS_W'(MAX_POINTS)) ? PTS_W'(MAX_POINTS) : cfg.point_count;

	assign gain = cfg.boost_enable ? prod1_q[Q_SHIFT+GAIN_W-1:Q_SHIFT] : GAIN_W'(vol_c);

	// Truncate toward zero: add one back for negative products with lost bits.
	assign q_trunc = QT_W'(prod2_q >>> Q_SHIFT)
		+ QT_W'(prod2_q[PROD2_W-1] && (prod2_q[Q_SHIFT-1:0] != '0));
	always_comb begin
		if (unity_q) begin
			sat_res = samp_q;
		end else if (q_trunc > QT_W'(32767)) begin
			sat_res = 16'h7FFF;
		end else if (q_trunc < -QT_W'(32768)) begin
			sat_res = 16'h8000;
		end else begin
			sat_res = q_trunc[SAMPLE_W-1:0];
		end
	end

	assign rd_addr = base_q + ADDR_W'(chan_q);
	assign mag = rd_data_s1[SAMPLE_W-1] ? ({1'b0, ~rd_data_s1} + MAG_W'(1))
		: MAG_W'(rd_data_s1);
	assign stride = (div_quo == '0) ? DIV_W'(1) : div_quo;
	assign step_full = stride * ch_c;
	assign lvl = (div_quo > DIV_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : div_quo[LEVEL_W-1:0];
	assign pt_last = (pt_q == pts_c - PTS_W'(1));

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		ring_we = 1'b0;
		rd_issue = 1'b0;
		div_start = 1'b0;
		div_dividend = DIV_W'(RING_DEPTH);
		div_divisor = DVS_W'(pts_c) * DVS_W'(ch_c);
		out_load = 1'b0;
		out_kind_d = KIND_SAMPLE;
		out_samp_d = '0;
		out_lvl_d = '0;
		out_last_d = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.is_read) begin
						div_start = 1'b1;
						state_d = ST_SDIV;
					end else begin
						state_d = ST_MUL1;
					end
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_samp_d = sat_res;
					ring_we = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SDIV: begin
				if (div_done) state_d = ST_RD;
			end
			ST_RD: begin
				rd_issue = 1'b1;
				if (chan_q == ch_c - CH_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_LGO;
			ST_LGO: begin
				div_start = 1'b1;
				div_dividend = DIV_W'({sum_q, 1'b0});
				div_divisor = DVS_W'(ch_c);
				state_d = ST_LDIV;
			end
			ST_LDIV: begin
				if (div_done) state_d = ST_LEMIT;
			end
			ST_LEMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind_d = KIND_LEVEL;
					out_lvl_d = lvl;
					out_last_d = pt_last;
					state_d = pt_last ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[write_pos_q] <= sat_res;
		rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) samp_q <= q_item.sample;
		prod1_q <= vol_c * cfg.boost_gain;
		if (state_q == ST_MUL2) begin
			unity_q <= (gain >= GAIN_W'(UNITY_LO)) && (gain <= GAIN_W'(UNITY_HI));
			prod2_q <= samp_q * $signed({1'b0, gain});
		end
		// Entries never written since reset read as zero.
		rd_ok_s1 <= wrapped_q || (rd_addr < write_pos_q);
		if (state_q == ST_SDIV && div_done) begin
			step_q <= step_full[ADDR_W-1:0];
			base_q <= write_pos_q;
			pt_q <= '0;
			chan_q <= '0;
			sum_q <= '0;
		end else if (rd_issue) begin
			chan_q <= chan_q + CH_W'(1);
		end else if (out_load && state_q == ST_LEMIT) begin
			pt_q <= pt_q + PTS_W'(1);
			base_q <= base_q + step_q;
			chan_q <= '0;
			sum_q <= '0;
		end
		if (rd_vld_s1 && rd_ok_s1) sum_q <= sum_q + SUM_W'(mag);
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_samp_q <= out_samp_d;
			out_lvl_q <= out_lvl_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			write_pos_q <= '0;
			wrapped_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= rd_issue;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (ring_we) begin
				write_pos_q <= write_pos_q + ADDR_W'(1);
				if (write_pos_q == ADDR_W'(RING_DEPTH - 1)) wrapped_q <= 1'b1;
			end
		end
	end

	gsl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_quo)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.kind = out_kind_q;
	assign rsp.sample_out = out_samp_q;
	assign rsp.level = out_lvl_q;
	assign rsp.last = out_last_q;

	`include "gain_saturate_level_meter_ring_macros.svh"

	`GSL_ASSERT_IMP(a_pop_in_idle, q_pop, state_q == ST_IDLE && q_valid, "pop outside idle")
	`GSL_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider restarted while busy")
	`GSL_ASSERT_IMP(a_ring_we, ring_we, state_q == ST_EMIT && out_free, "stray ring write")
	`GSL_ASSERT_NXT(a_pos_step, ring_we, write_pos_q == ADDR_W'($past(write_pos_q) + 1'b1),
		"write position did not advance")
	`GSL_ASSERT_NXT(a_level_max, out_load && state_q == ST_LEMIT,
		rsp.level <= LEVEL_W'(LEVEL_MAX), "level above full scale")
endmodule

// ===== hdl/gain_saturate_level_meter_ring.sv =====
// Top level of the PCM gain, saturate and level meter ring block.
// Depends on gsl_pkg, gsl_if, gsl_front and gsl_back.
//
// Words arrive on req: cmd 0 carries a signed 16-bit sample, cmd 1 asks
// for a set of level points. Results leave on rsp; every word has kind,
// sample_out, level and last, and last marks the final result of a request.
// A sample word passes the queue hand-off in IDLE and the two multiply stages
// MUL1 and MUL2 of the gain path, then EMIT gives one scaled, saturated sample,
// and the back end takes no new word until EMIT has loaded that result.
// The scaled sample is also stored in the level ring at the write position.
// A read word first divides the ring size by points times channels in the
// shared bit-serial divider, then each point takes channel_count ring reads,
// one per cycle, a divide of twice the sum by channel_count and the hand-off
// to the output register.
// A two-entry queue in the front end feeds the back end, so up to two
// requests are taken while the back end is busy or the receiver stalls.
// A stalled receiver holds the output register; the back end waits on it.
// Reset clears all control state and restores the register defaults. The
// ring is not swept: entries at or beyond the write position read as zero until
// the write position first wraps, so the block is ready right after reset.
// Configuration writes are taken in any cycle but belong to idle periods.
module gain_saturate_level_meter_ring import gsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gsl_req_if.sink req,
	gsl_rsp_if.source rsp,
	input  logic cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t cfg_q;
	item_t q_item;
	logic q_valid;
	logic q_pop;

	// Register file; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume <= VOL_W'(VOL_MAX);
			cfg_q.boost_enable <= 1'b0;
			cfg_q.boost_gain <= BOOST_W'(8192);
			cfg_q.channel_count <= CH_W'(2);
			cfg_q.point_count <= PTS_W'(64);
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_VOLUME: cfg_q.volume <= cfg_data[VOL_W-1:0];
				CFG_BOOST_EN: cfg_q.boost_enable <= cfg_data[0];
				CFG_BOOST_GAIN: cfg_q.boost_gain <= cfg_data[BOOST_W-1:0];
				CFG_CHANNELS: cfg_q.channel_count <= cfg_data[CH_W-1:0];
				CFG_POINTS: cfg_q.point_count <= cfg_data[PTS_W-1:0];
				default: ;
			endcase
		end
	end

	gsl_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.q_item(q_item),
		.q_valid(q_valid),
		.q_pop(q_pop)
	);

	gsl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_item(q_item),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.rsp(rsp)
	);
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the gain, saturate and level meter ring block.
// Depends on gsl_pkg, gsl_if and the block's top module gain_saturate_level_meter_ring.
module tb_top;
	import gsl_pkg::*;

	// One expected result word as it should leave the rsp channel.
	typedef struct {
		logic kind;
		logic [SAMPLE_W-1:0] sample_out;
		logic [LEVEL_W-1:0] level;
		logic last;
	} rsp_word_t;

	// One row of the directed table. When typed is set, the sample word's
	// result is the one written in the row rather than the computed one.
	typedef struct {
		logic cmd;
		logic [SAMPLE_W-1:0] sample;
		bit typed;
		logic [SAMPLE_W-1:0] want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gsl_req_if req ();
	gsl_rsp_if rsp ();

	gain_saturate_level_meter_ring uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the block's registers and ring, kept at its widths.
	logic [VOL_W-1:0] sh_volume;
	logic sh_boost_en;
	logic [BOOST_W-1:0] sh_boost_gain;
	logic [CH_W-1:0] sh_channels;
	logic [PTS_W-1:0] sh_points;
	logic [SAMPLE_W-1:0] sh_ring [RING_DEPTH];
	logic [ADDR_W-1:0] sh_wpos;

	rsp_word_t pending_words[$];
	int mismatches = 0;
	bit jitter = 1'b1;

	// Effective gain times the sample, truncated toward zero and saturated.
	// Gains in the band around unity pass the sample through untouched.
	function automatic logic [SAMPLE_W-1:0] scaled_sample(logic [SAMPLE_W-1:0] raw);
		longint vol;
		longint g;
		longint prod;
		longint q;
		vol = (sh_volume > VOL_MAX) ? VOL_MAX : sh_volume;
		g = vol;
		if (sh_boost_en)
			g = (vol * longint'(sh_boost_gain)) >>> Q_SHIFT;
		if (g >= UNITY_LO && g <= UNITY_HI)
			return raw;
		prod = longint'($signed(raw)) * g;
		q = prod / 4096;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[SAMPLE_W-1:0];
	endfunction

	// Works out all result words that one accepted request causes and
	// updates the shadow ring for sample words.
	task automatic predict_words(input logic c, input logic [SAMPLE_W-1:0] s,
			input bit typed, input logic [SAMPLE_W-1:0] want);
		rsp_word_t w;
		longint ch;
		longint pts;
		longint stride;
		longint base;
		longint sum;
		longint lvl;
		logic [SAMPLE_W-1:0] e;
		if (c == CMD_SAMPLE) begin
			w.kind = KIND_SAMPLE;
			w.sample_out = typed ? want : scaled_sample(s);
			w.level = '0;
			w.last = 1'b1;
			sh_ring[sh_wpos] = scaled_sample(s);
			sh_wpos = sh_wpos + 1'b1;
			pending_words.push_back(w);
		end else begin
			ch = (sh_channels == 0) ? 1 : ((sh_channels > MAX_CH) ? MAX_CH : sh_channels);
			pts = (sh_points == 0) ? 1 :
				((sh_points > MAX_POINTS) ? MAX_POINTS : sh_points);
			stride = RING_DEPTH / (pts * ch);
			if (stride == 0) stride = 1;
			for (longint i = 0; i < pts; i++) begin
				base = longint'(sh_wpos) + i * stride * ch;
				sum = 0;
				for (longint k = 0; k < ch; k++) begin
					e = sh_ring[(base + k) % RING_DEPTH];
					sum += ($signed(e) < 0) ? -longint'($signed(e)) : longint'($signed(e));
				end
				lvl = (2 * sum) / ch;
				if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
				w.kind = KIND_LEVEL;
				w.sample_out = '0;
				w.level = lvl[LEVEL_W-1:0];
				w.last = (i + 1 == pts);
				pending_words.push_back(w);
			end
		end
	endtask

	// Random receiver stalls, switched off while jitter is low.
	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= jitter ? ($urandom_range(99) >= 24) : 1'b1;
	end

	// Every accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin
		rsp_word_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word kind=%0b sample_out=%0d level=%0d last=%0b",
					$time, rsp.kind, rsp.sample_out, rsp.level, rsp.last);
				mismatches++;
			end else begin
				w = pending_words.pop_front();
				if (rsp.kind !== w.kind) begin
					$display("%0t: kind expected %0b actual %0b", $time, w.kind, rsp.kind);
					mismatches++;
				end
				if (rsp.sample_out !== w.sample_out) begin
					$display("%0t: sample_out expected %0d actual %0d", $time,
						$signed(w.sample_out), rsp.sample_out);
					mismatches++;
				end
				if (rsp.level !== w.level) begin
					$display("%0t: level expected %0d actual %0d", $time, w.level, rsp.level);
					mismatches++;
				end
				if (rsp.last !== w.last) begin
					$display("%0t: last expected %0b actual %0b", $time, w.last, rsp.last);
					mismatches++;
				end
			end
		end
	end

	// Offers one request word and holds it until the block takes it. The
	// valid line is lowered only in idle cycles, so back-to-back words keep
	// it high with a single assignment per edge.
	task automatic send_word(input logic c, input logic [SAMPLE_W-1:0] s,
			input bit typed = 1'b0, input logic [SAMPLE_W-1:0] want = '0);
		while (jitter && $urandom_range(99) < 24) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.sample_in <= s;
		do @(posedge clk); while (!req.ready);
		predict_words(c, s, typed, want);
	endtask

	// Holds the sender until every expected word has arrived, then lets
	// the back end settle before anything else happens.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Writes one register and mirrors it into the shadow copy. The write
	// enable is left high; the caller lowers it after a batch of writes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			CFG_VOLUME: sh_volume = d[VOL_W-1:0];
			CFG_BOOST_EN: sh_boost_en = d[0];
			CFG_BOOST_GAIN: sh_boost_gain = d[BOOST_W-1:0];
			CFG_CHANNELS: sh_channels = d[CH_W-1:0];
			CFG_POINTS: sh_points = d[PTS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int vol, input int ben, input int bg, input int ch,
			input int pts);
		write_reg(CFG_VOLUME, CFG_DATA_W'(vol));
		write_reg(CFG_BOOST_EN, CFG_DATA_W'(ben));
		write_reg(CFG_BOOST_GAIN, CFG_DATA_W'(bg));
		write_reg(CFG_CHANNELS, CFG_DATA_W'(ch));
		write_reg(CFG_POINTS, CFG_DATA_W'(pts));
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_W'($urandom_range(15) - 8);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// Directed rows: with the reset registers the gain is unity, so sample
	// words come back unchanged and their results can be typed in.
	dir_row_t dir_rows [11] = '{
		'{CMD_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF},
		'{CMD_SAMPLE, 16'h8000, 1'b1, 16'h8000},
		'{CMD_SAMPLE, 16'h0000, 1'b1, 16'h0000},
		'{CMD_SAMPLE, 16'h0001, 1'b1, 16'h0001},
		'{CMD_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF},
		'{CMD_SAMPLE, 16'h5555, 1'b1, 16'h5555},
		'{CMD_SAMPLE, 16'hAAAA, 1'b1, 16'hAAAA},
		'{CMD_READ, 16'h0000, 1'b0, 16'h0000},
		'{CMD_SAMPLE, 16'h8000, 1'b1, 16'h8000},
		'{CMD_SAMPLE, 16'h8000, 1'b1, 16'h8000},
		'{CMD_READ, 16'hFFFF, 1'b0, 16'h0000}
	};

	// Register settings per phase: volume, boost enable, boost gain,
	// channels, points. They cover mute, the clamped volume, the largest
	// boost, boosted gains that land in the unity band, and channel and
	// point counts of zero and beyond their maximum.
	int phase_cfg [7][5] = '{
		'{0, 0, 4096, 1, 1},
		'{8191, 1, 16383, 8, 64},
		'{2048, 1, 8192, 0, 0},
		'{4095, 1, 4097, 15, 127},
		'{4096, 1, 4096, 3, 5},
		'{1, 1, 16383, 2, 3},
		'{3000, 0, 8192, 1, 2}
	};

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_SAMPLE;
		req.sample_in = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sh_volume = VOL_MAX;
		sh_boost_en = 1'b0;
		sh_boost_gain = 14'd8192;
		sh_channels = 4'd2;
		sh_points = 7'd64;
		sh_wpos = '0;
		foreach (sh_ring[i]) sh_ring[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].cmd, dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();

		for (int p = 0; p < 7 + 2; p++) begin
			if (p < 7) begin
				set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
					phase_cfg[p][3], phase_cfg[p][4]);
			end else begin
				set_config($urandom_range(8191), $urandom_range(1), $urandom_range(16383),
					$urandom_range(15), $urandom_range(127));
			end
			// An index past the register list must leave everything alone.
			write_reg(CFG_IDX_W'(5 + $urandom_range(2)), CFG_DATA_W'($urandom()));
			cfg_write <= 1'b0;
			@(posedge clk);
			// One phase runs with both sides always willing.
			jitter = (p != 4);
			for (int n = 0; n < 45; n++) begin
				if ($urandom_range(99) < 12)
					send_word(CMD_READ, SAMPLE_W'($urandom()));
				else
					send_word(CMD_SAMPLE, pick_sample());
			end
			wait_drained();
		end

		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
